// ----- hdl/r2q_pkg.sv -----
`default_nettype none
package r2q_pkg;
  localparam int FRAC_BITS  = 14;
  localparam int IN_W       = 16;
  localparam int MAG_W      = 17;
  localparam int T_W        = 17;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int N_W        = 48;
  localparam int QUO_W      = 32;
  localparam int REM_W      = 17;
  localparam int ROOT_W     = QUO_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int LANE_LAT   = 3 + QUO_W + ROOT_W;
  localparam int LAT        = LANE_LAT + 1;
  localparam int NUM_COMP   = 4;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } r2q_comp_t;

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } r2q_sel_t;
endpackage
`default_nettype wire

// ----- hdl/rotation_matrix_to_quaternion.sv -----
`default_nettype none
// Converts one 3x3 rotation basis to a unit quaternion (w, i, j, k), Q1.14 in and out,
// rounded to nearest and saturated. An item is accepted every cycle while the output
// side keeps up; each result comes through the per-component divider (one quotient bit
// per stage, 32 stages) followed by the square root (one root bit per stage, 16 stages).
// A stall at the output freezes the whole pipeline.
module rotation_matrix_to_quaternion (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
  input  wire logic [143:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // quat_w, quat_i, quat_j, quat_k
  output logic [63:0]        out_tdata
);
  import r2q_pkg::*;

  logic               en;
  logic [LAT-1:0]     vld_r;
  logic [LAT-1:0]     vld_nxt;
  r2q_comp_t          fr_comp [NUM_COMP];
  logic [T_W-1:0]     fr_t;
  logic [IN_W-1:0]    res [NUM_COMP];

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];
  assign vld_nxt    = {vld_r[LAT-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  r2q_front u_front (
    .clk    (clk),
    .en     (en),
    .mat    (in_tdata),
    .comp_r (fr_comp),
    .t_r    (fr_t)
  );

  for (genvar i = 0; i < NUM_COMP; i++) begin : g_lane
    r2q_lane u_lane (
      .clk   (clk),
      .en    (en),
      .comp  (fr_comp[i]),
      .t     (fr_t),
      .res_r (res[i])
    );
    assign out_tdata[i*IN_W +: IN_W] = res[i];
  end

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item not in first stage");

  a_t_positive: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> fr_t != '0)
    else $error("t not clamped");
endmodule
`default_nettype wire

// ----- hdl/r2q_front.sv -----
`default_nettype none
module r2q_front (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [9*r2q_pkg::IN_W-1:0]    mat,
  output r2q_pkg::r2q_comp_t                 comp_r [r2q_pkg::NUM_COMP],
  output logic [r2q_pkg::T_W-1:0]            t_r
);
  import r2q_pkg::*;

  localparam int W = 19;

  logic signed [W-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz, one, t_raw, t_cl;
  logic signed [W-1:0] q [NUM_COMP];
  r2q_sel_t            sel;
  r2q_comp_t           comp_nxt [NUM_COMP];

  function automatic logic signed [W-1:0] ext(input logic [IN_W-1:0] v);
    ext = W'(signed'(v));
  endfunction

  always_comb begin
    xx  = ext(mat[0*IN_W +: IN_W]);
    xy  = ext(mat[1*IN_W +: IN_W]);
    xz  = ext(mat[2*IN_W +: IN_W]);
    yx  = ext(mat[3*IN_W +: IN_W]);
    yy  = ext(mat[4*IN_W +: IN_W]);
    yz  = ext(mat[5*IN_W +: IN_W]);
    zx  = ext(mat[6*IN_W +: IN_W]);
    zy  = ext(mat[7*IN_W +: IN_W]);
    zz  = ext(mat[8*IN_W +: IN_W]);
    one = W'(1 << FRAC_BITS);
    if (zz < 0) begin
      sel = (xx > yy) ? SEL_X : SEL_Y;
    end else begin
      sel = (xx < -yy) ? SEL_Z : SEL_W;
    end
    case (sel)
      SEL_X:   t_raw = one + xx - yy - zz;
      SEL_Y:   t_raw = one - xx + yy - zz;
      SEL_Z:   t_raw = one - xx - yy + zz;
      default: t_raw = one + xx + yy + zz;
    endcase
    t_cl = (t_raw < 1) ? W'(1) : t_raw;
    case (sel)
      SEL_X: begin
        q[0] = yz - zy; q[1] = t_cl;    q[2] = xy + yx; q[3] = zx + xz;
      end
      SEL_Y: begin
        q[0] = zx - xz; q[1] = xy + yx; q[2] = t_cl;    q[3] = yz + zy;
      end
      SEL_Z: begin
        q[0] = xy - yx; q[1] = zx + xz; q[2] = yz + zy; q[3] = t_cl;
      end
      default: begin
        q[0] = t_cl;    q[1] = yz - zy; q[2] = zx - xz; q[3] = xy - yx;
      end
    endcase
    for (int i = 0; i < NUM_COMP; i++) begin
      comp_nxt[i].neg = q[i] < 0;
      comp_nxt[i].mag = (q[i] < 0) ? MAG_W'(-q[i]) : MAG_W'(q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp_r <= comp_nxt;
      t_r    <= T_W'(t_cl);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/r2q_lane.sv -----
`default_nettype none
module r2q_lane (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire r2q_pkg::r2q_comp_t         comp,
  input  wire logic [r2q_pkg::T_W-1:0]    t,
  output logic [r2q_pkg::IN_W-1:0]        res_r
);
  import r2q_pkg::*;

  logic [SQ_W-1:0]  sq_r;
  logic [T_W-1:0]   sq_t_r;
  logic             sq_neg_r;
  logic [N_W-1:0]   n;

  logic [REM_W-1:0] rem_r  [QUO_W+1];
  logic [QUO_W-1:0] lo_r   [QUO_W+1];
  logic [QUO_W-1:0] quo_r  [QUO_W+1];
  logic [T_W-1:0]   dt_r   [QUO_W+1];
  logic             dneg_r [QUO_W+1];
  logic             dov_r  [QUO_W+1];

  logic [QUO_W-1:0]  rad_r  [ROOT_W+1];
  logic [ROOT_W-1:0] root_r [ROOT_W+1];
  logic [SREM_W-1:0] srem_r [ROOT_W+1];
  logic              sneg_r [ROOT_W+1];
  logic              sov_r  [ROOT_W+1];

  logic [MAG_W-1:0] m;
  logic [IN_W-1:0]  res_nxt;

  assign n = N_W'(sq_r) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r      <= SQ_W'(comp.mag) * SQ_W'(comp.mag);
      sq_t_r    <= t;
      sq_neg_r  <= comp.neg;
      rem_r[0]  <= REM_W'(n[N_W-1:QUO_W]);
      lo_r[0]   <= n[QUO_W-1:0];
      quo_r[0]  <= '0;
      dt_r[0]   <= sq_t_r;
      dneg_r[0] <= sq_neg_r;
      dov_r[0]  <= REM_W'(n[N_W-1:QUO_W]) >= sq_t_r;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    logic [REM_W:0] cat;
    logic           ge;
    always_comb begin
      cat = {rem_r[k-1], lo_r[k-1][QUO_W-1]};
      ge  = cat >= {1'b0, dt_r[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? REM_W'(cat - {1'b0, dt_r[k-1]}) : REM_W'(cat);
        lo_r[k]   <= {lo_r[k-1][QUO_W-2:0], 1'b0};
        quo_r[k]  <= {quo_r[k-1][QUO_W-2:0], ge};
        dt_r[k]   <= dt_r[k-1];
        dneg_r[k] <= dneg_r[k-1];
        dov_r[k]  <= dov_r[k-1];
      end
    end
  end

  always_comb begin
    rad_r[0]  = quo_r[QUO_W];
    root_r[0] = '0;
    srem_r[0] = '0;
    sneg_r[0] = dneg_r[QUO_W];
    sov_r[0]  = dov_r[QUO_W];
  end

  for (genvar s = 1; s <= ROOT_W; s++) begin : g_sqrt
    logic [SREM_W+1:0] cat;
    logic [SREM_W+1:0] trial;
    logic              ge;
    always_comb begin
      cat   = {srem_r[s-1], rad_r[s-1][QUO_W-1:QUO_W-2]};
      trial = (SREM_W+2)'({root_r[s-1], 2'b01});
      ge    = cat >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[s] <= ge ? SREM_W'(cat - trial) : SREM_W'(cat);
        root_r[s] <= {root_r[s-1][ROOT_W-2:0], ge};
        rad_r[s]  <= {rad_r[s-1][QUO_W-3:0], 2'b00};
        sneg_r[s] <= sneg_r[s-1];
        sov_r[s]  <= sov_r[s-1];
      end
    end
  end

  always_comb begin
    if (sov_r[ROOT_W]) begin
      m = MAG_W'(1 << (IN_W - 1));
    end else begin
      m = (MAG_W'(root_r[ROOT_W]) + MAG_W'(1)) >> 1;
    end
    if (sneg_r[ROOT_W]) begin
      res_nxt = IN_W'(-m);
    end else if (m > MAG_W'((1 << (IN_W - 1)) - 1)) begin
      res_nxt = IN_W'((1 << (IN_W - 1)) - 1);
    end else begin
      res_nxt = IN_W'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end
endmodule
`default_nettype wire
